[rtl/abqf_pkg.sv]
// Package for the alignment block quality filter.
// Holds the back-end state type, register indexes and fixed constants.
// Has no dependencies.
package abqf_pkg;

  localparam int unsigned CODE_BITS = 8;
  localparam logic [CODE_BITS-1:0] CODE_N = 8'd110;

  localparam int unsigned REG_IDX_BITS = 3;
  localparam int unsigned ADDR_BITS = 5;
  localparam int unsigned DATA_BITS = 32;

  localparam logic [REG_IDX_BITS-1:0] REG_TARGET_OFFSET  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_QUERY_SIZE     = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_REVERSE_STRAND = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_MRNA_MODE      = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_MIN_MATCH      = 3'd4;

  localparam int unsigned MIN_MATCH_RESET = 50;
  localparam logic MRNA_MODE_RESET = 1'b1;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIF,
    B_SUM,
    B_CMP,
    B_OUT
  } back_state_t;

endpackage

[rtl/abqf_if.sv]
// Channel interfaces for the alignment block quality filter.
// abqf_pair_if carries aligned base pairs, abqf_result_if carries results.
// Depends on abqf_pkg for the character code width.
interface abqf_pair_if #(
  parameter int unsigned POS_BITS = 28
);
  logic                              valid;
  logic                              ready;
  logic [abqf_pkg::CODE_BITS-1:0]    query_base;
  logic [abqf_pkg::CODE_BITS-1:0]    target_base;
  logic [POS_BITS-1:0]               query_pos;
  logic [POS_BITS-1:0]               target_pos;
  logic                              last_pair;

  modport source (
    output valid, query_base, target_base, query_pos, target_pos, last_pair,
    input  ready
  );
  modport sink (
    input  valid, query_base, target_base, query_pos, target_pos, last_pair,
    output ready
  );
endinterface

interface abqf_result_if #(
  parameter int unsigned POS_BITS = 28
);
  logic                valid;
  logic                ready;
  logic                pass;
  logic [POS_BITS-1:0] match_count;
  logic [POS_BITS-1:0] mismatch_count;
  logic [POS_BITS-1:0] n_count;
  logic [POS_BITS-1:0] query_gap_count;
  logic [POS_BITS-1:0] query_gap_bases;
  logic [POS_BITS-1:0] target_gap_count;
  logic [POS_BITS-1:0] target_gap_bases;
  logic [POS_BITS-1:0] query_start;
  logic [POS_BITS-1:0] query_end;
  logic [POS_BITS-1:0] target_start;
  logic [POS_BITS-1:0] target_end;

  modport source (
    output valid, pass, match_count, mismatch_count, n_count, query_gap_count,
           query_gap_bases, target_gap_count, target_gap_bases, query_start,
           query_end, target_start, target_end,
    input  ready
  );
  modport sink (
    input  valid, pass, match_count, mismatch_count, n_count, query_gap_count,
           query_gap_bases, target_gap_count, target_gap_bases, query_start,
           query_end, target_start, target_end,
    output ready
  );
endinterface

[rtl/abqf_front.sv]
// Front end: accepts one base pair per cycle unless the summary queue is full,
// and accumulates the counts. On the last pair it pushes an alignment summary
// into the queue. Depends on abqf_pkg and abqf_if.
module abqf_front #(
  parameter int unsigned POS_BITS = 28,
  parameter int unsigned SUM_BITS = 11 * POS_BITS
) (
  input  logic                clk,
  input  logic                rst,
  abqf_pair_if.sink           pairs,
  input  logic                full,
  output logic                push,
  output logic [SUM_BITS-1:0] push_data
);

  typedef struct packed {
    logic [POS_BITS-1:0] match_cnt;
    logic [POS_BITS-1:0] mismatches;
    logic [POS_BITS-1:0] n_pairs;
    logic [POS_BITS-1:0] q_gaps;
    logic [POS_BITS-1:0] q_gap_sum;
    logic [POS_BITS-1:0] t_gaps;
    logic [POS_BITS-1:0] t_gap_sum;
    logic [POS_BITS-1:0] first_q;
    logic [POS_BITS-1:0] first_t;
    logic [POS_BITS-1:0] last_q;
    logic [POS_BITS-1:0] last_t;
  } summary_t;

  function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] a,
                                                  input logic [POS_BITS-1:0] b);
    logic [POS_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[POS_BITS] ? {POS_BITS{1'b1}} : s[POS_BITS-1:0];
  endfunction

  logic                aln_open;
  logic [POS_BITS-1:0] match_cnt, mismatches, n_pairs;
  logic [POS_BITS-1:0] q_gaps, q_gap_sum, t_gaps, t_gap_sum;
  logic [POS_BITS-1:0] first_q, first_t, prev_q, prev_t;

  logic                accept;
  logic [POS_BITS:0]   q_expect, t_expect, q_skip, t_skip;
  logic                q_gap, t_gap, q_fwd, t_fwd, has_n, is_match;
  summary_t            nxt;

  assign pairs.ready = !full;
  assign accept = pairs.valid && pairs.ready;
  assign push = accept && pairs.last_pair;
  assign push_data = nxt;

  always_comb begin
    q_expect = {1'b0, prev_q} + 1'b1;
    t_expect = {1'b0, prev_t} + 1'b1;
    q_gap = aln_open && ({1'b0, pairs.query_pos} != q_expect);
    t_gap = aln_open && ({1'b0, pairs.target_pos} != t_expect);
    q_fwd = {1'b0, pairs.query_pos} > q_expect;
    t_fwd = {1'b0, pairs.target_pos} > t_expect;
    q_skip = {1'b0, pairs.query_pos} - q_expect;
    t_skip = {1'b0, pairs.target_pos} - t_expect;
    has_n = (pairs.query_base == abqf_pkg::CODE_N) ||
            (pairs.target_base == abqf_pkg::CODE_N);
    is_match = !has_n && (pairs.query_base == pairs.target_base);

    nxt.match_cnt  = aln_open ? match_cnt : '0;
    nxt.mismatches = aln_open ? mismatches : '0;
    nxt.n_pairs    = aln_open ? n_pairs : '0;
    nxt.q_gaps     = aln_open ? q_gaps : '0;
    nxt.q_gap_sum  = aln_open ? q_gap_sum : '0;
    nxt.t_gaps     = aln_open ? t_gaps : '0;
    nxt.t_gap_sum  = aln_open ? t_gap_sum : '0;
    nxt.first_q    = aln_open ? first_q : pairs.query_pos;
    nxt.first_t    = aln_open ? first_t : pairs.target_pos;
    nxt.last_q     = pairs.query_pos;
    nxt.last_t     = pairs.target_pos;

    if (has_n) begin
      nxt.n_pairs = sat_add(nxt.n_pairs, POS_BITS'(1));
    end else if (is_match) begin
      nxt.match_cnt = sat_add(nxt.match_cnt, POS_BITS'(1));
    end else begin
      nxt.mismatches = sat_add(nxt.mismatches, POS_BITS'(1));
    end
    if (q_gap) begin
      nxt.q_gaps = sat_add(nxt.q_gaps, POS_BITS'(1));
      if (q_fwd) begin
        nxt.q_gap_sum = sat_add(nxt.q_gap_sum, q_skip[POS_BITS-1:0]);
      end
    end
    if (t_gap) begin
      nxt.t_gaps = sat_add(nxt.t_gaps, POS_BITS'(1));
      if (t_fwd) begin
        nxt.t_gap_sum = sat_add(nxt.t_gap_sum, t_skip[POS_BITS-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      aln_open <= 1'b0;
    end else if (accept) begin
      aln_open <= !pairs.last_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      match_cnt  <= nxt.match_cnt;
      mismatches <= nxt.mismatches;
      n_pairs    <= nxt.n_pairs;
      q_gaps     <= nxt.q_gaps;
      q_gap_sum  <= nxt.q_gap_sum;
      t_gaps     <= nxt.t_gaps;
      t_gap_sum  <= nxt.t_gap_sum;
      first_q    <= nxt.first_q;
      first_t    <= nxt.first_t;
      prev_q     <= pairs.query_pos;
      prev_t     <= pairs.target_pos;
    end
  end

endmodule

[rtl/abqf_queue.sv]
// Two-entry queue of alignment summaries between front and back end.
// Written at one entry and read at one entry per cycle.
// Has no dependencies.
module abqf_queue #(
  parameter int unsigned WIDTH = 308
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;

  assign full = count[1];
  assign empty = (count == 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/abqf_back.sv]
// Back end: takes one alignment summary, works out the badness test and
// the spans in the DIF, SUM and CMP states, and holds the result until it is taken.
// Depends on abqf_pkg and abqf_if.
module abqf_back #(
  parameter int unsigned POS_BITS = 28,
  parameter int unsigned SUM_BITS = 11 * POS_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  logic [SUM_BITS-1:0] pop_data,
  output logic                pop,
  input  logic [POS_BITS-1:0] target_offset,
  input  logic [POS_BITS-1:0] query_size,
  input  logic                reverse_strand,
  input  logic                mrna_mode,
  input  logic [POS_BITS-1:0] min_match,
  abqf_result_if.source       results
);

  typedef struct packed {
    logic [POS_BITS-1:0] match_cnt;
    logic [POS_BITS-1:0] mismatches;
    logic [POS_BITS-1:0] n_pairs;
    logic [POS_BITS-1:0] q_gaps;
    logic [POS_BITS-1:0] q_gap_sum;
    logic [POS_BITS-1:0] t_gaps;
    logic [POS_BITS-1:0] t_gap_sum;
    logic [POS_BITS-1:0] first_q;
    logic [POS_BITS-1:0] first_t;
    logic [POS_BITS-1:0] last_q;
    logic [POS_BITS-1:0] last_t;
  } summary_t;

  localparam int unsigned X_BITS = POS_BITS + 3;
  localparam int unsigned TEN_BITS = X_BITS + 4;

  function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] a,
                                                  input logic [POS_BITS-1:0] b);
    logic [POS_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[POS_BITS] ? {POS_BITS{1'b1}} : s[POS_BITS-1:0];
  endfunction

  abqf_pkg::back_state_t state, state_next;
  summary_t              sum;
  logic [POS_BITS:0]     dif_mag, ins;
  logic [POS_BITS-1:0]   q_end_sat, t_end_sat;
  logic [X_BITS-1:0]     bad_sum;
  logic [POS_BITS-1:0]   q_lo, q_hi, t_lo, t_hi;

  logic                  pass;
  logic [POS_BITS-1:0]   query_start, query_end, target_start, target_end;

  logic signed [POS_BITS+1:0] dq, dt, dif;
  logic [TEN_BITS-1:0]        ten_x;

  always_comb begin
    dq = $signed({2'b00, sum.last_q}) - $signed({2'b00, sum.first_q});
    dt = $signed({2'b00, sum.last_t}) - $signed({2'b00, sum.first_t});
    dif = dq - dt;
    ten_x = {bad_sum, 3'b000} + {2'b00, bad_sum, 1'b0};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      abqf_pkg::B_IDLE: begin
        if (!empty) begin
          state_next = abqf_pkg::B_DIF;
        end
      end
      abqf_pkg::B_DIF: state_next = abqf_pkg::B_SUM;
      abqf_pkg::B_SUM: state_next = abqf_pkg::B_CMP;
      abqf_pkg::B_CMP: state_next = abqf_pkg::B_OUT;
      abqf_pkg::B_OUT: begin
        if (results.ready) begin
          state_next = abqf_pkg::B_IDLE;
        end
      end
      default: state_next = abqf_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop = (state == abqf_pkg::B_IDLE) && !empty;
    results.valid = (state == abqf_pkg::B_OUT);
    results.pass = pass;
    results.match_count = sum.match_cnt;
    results.mismatch_count = sum.mismatches;
    results.n_count = sum.n_pairs;
    results.query_gap_count = sum.q_gaps;
    results.query_gap_bases = sum.q_gap_sum;
    results.target_gap_count = sum.t_gaps;
    results.target_gap_bases = sum.t_gap_sum;
    results.query_start = query_start;
    results.query_end = query_end;
    results.target_start = target_start;
    results.target_end = target_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abqf_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      abqf_pkg::B_IDLE: begin
        if (!empty) begin
          sum <= pop_data;
        end
      end
      abqf_pkg::B_DIF: begin
        if (dif < 0) begin
          dif_mag <= mrna_mode ? '0 : (POS_BITS+1)'(-dif);
        end else begin
          dif_mag <= (POS_BITS+1)'(dif);
        end
        ins <= {1'b0, sum.q_gaps} + (mrna_mode ? '0 : {1'b0, sum.t_gaps});
        q_end_sat <= sat_add(sum.last_q, POS_BITS'(1));
        t_end_sat <= sat_add(sum.last_t, POS_BITS'(1));
      end
      abqf_pkg::B_SUM: begin
        bad_sum <= X_BITS'(sum.mismatches) + X_BITS'(ins) + X_BITS'(dif_mag);
        if (reverse_strand) begin
          q_lo <= (query_size >= q_end_sat) ? query_size - q_end_sat : '0;
          q_hi <= (query_size >= sum.first_q) ? query_size - sum.first_q : '0;
        end else begin
          q_lo <= sum.first_q;
          q_hi <= q_end_sat;
        end
        t_lo <= sat_add(sum.first_t, target_offset);
        t_hi <= sat_add(t_end_sat, target_offset);
      end
      abqf_pkg::B_CMP: begin
        pass <= (sum.match_cnt != '0) && (ten_x < TEN_BITS'(sum.match_cnt)) &&
                (sum.match_cnt >= min_match);
        query_start <= q_lo;
        query_end <= q_hi;
        target_start <= t_lo;
        target_end <= t_hi;
      end
      abqf_pkg::B_OUT: begin
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/alignment_block_quality_filter.sv]
// Alignment block quality filter, top level. Depends on abqf_pkg, abqf_if,
// abqf_front, abqf_queue and abqf_back.
// Throughput: one base pair per cycle, held only when the summary queue is full.
// A result is shown once its summary has passed the queue and the back end's DIF,
// SUM and CMP states; the back end pops the next summary only once it is taken.
// Reset is synchronous and active high; it empties the queue and loads defaults.
module alignment_block_quality_filter #(
  parameter int unsigned POS_BITS = 28
) (
  input  logic                                 clk,
  input  logic                                 rst,
  abqf_pair_if.sink                            pairs,
  abqf_result_if.source                        results,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [abqf_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [abqf_pkg::DATA_BITS-1:0]       pwdata,
  output logic [abqf_pkg::DATA_BITS-1:0]       prdata,
  output logic                                 pready
);

  localparam int unsigned SUM_BITS = 11 * POS_BITS;

  logic [POS_BITS-1:0] target_offset, query_size, min_match;
  logic                reverse_strand, mrna_mode;
  logic                cfg_write;
  logic [abqf_pkg::REG_IDX_BITS-1:0] reg_idx;

  logic                push, pop, full, empty;
  logic [SUM_BITS-1:0] push_data, pop_data;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx = paddr[abqf_pkg::ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      target_offset  <= '0;
      query_size     <= '0;
      reverse_strand <= 1'b0;
      mrna_mode      <= abqf_pkg::MRNA_MODE_RESET;
      min_match      <= POS_BITS'(abqf_pkg::MIN_MATCH_RESET);
    end else if (cfg_write) begin
      unique case (reg_idx)
        abqf_pkg::REG_TARGET_OFFSET:  target_offset <= pwdata[POS_BITS-1:0];
        abqf_pkg::REG_QUERY_SIZE:     query_size <= pwdata[POS_BITS-1:0];
        abqf_pkg::REG_REVERSE_STRAND: reverse_strand <= pwdata[0];
        abqf_pkg::REG_MRNA_MODE:      mrna_mode <= pwdata[0];
        abqf_pkg::REG_MIN_MATCH:      min_match <= pwdata[POS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      abqf_pkg::REG_TARGET_OFFSET:  prdata = abqf_pkg::DATA_BITS'(target_offset);
      abqf_pkg::REG_QUERY_SIZE:     prdata = abqf_pkg::DATA_BITS'(query_size);
      abqf_pkg::REG_REVERSE_STRAND: prdata = abqf_pkg::DATA_BITS'(reverse_strand);
      abqf_pkg::REG_MRNA_MODE:      prdata = abqf_pkg::DATA_BITS'(mrna_mode);
      abqf_pkg::REG_MIN_MATCH:      prdata = abqf_pkg::DATA_BITS'(min_match);
      default:                      prdata = '0;
    endcase
  end

  abqf_front #(
    .POS_BITS (POS_BITS),
    .SUM_BITS (SUM_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pairs     (pairs),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  abqf_queue #(
    .WIDTH (SUM_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  abqf_back #(
    .POS_BITS (POS_BITS),
    .SUM_BITS (SUM_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .empty          (empty),
    .pop_data       (pop_data),
    .pop            (pop),
    .target_offset  (target_offset),
    .query_size     (query_size),
    .reverse_strand (reverse_strand),
    .mrna_mode      (mrna_mode),
    .min_match      (min_match),
    .results        (results)
  );

endmodule
